@@ sv/tlpt_pkg.sv @@
package tlpt_pkg;

  localparam int unsigned TablePool       = 16;
  localparam int unsigned EntriesPerTable = 1024;
  localparam int unsigned RootEntries     = 512;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned RIDX_W     = $clog2(RootEntries);
  localparam int unsigned LIDX_W     = $clog2(EntriesPerTable);
  localparam int unsigned CNT_W      = (LIDX_W > RIDX_W) ? LIDX_W : RIDX_W;
  localparam int unsigned SLOT_W     = (TablePool > 1) ? $clog2(TablePool) : 1;
  localparam int unsigned USED_W     = $clog2(TablePool + 1);
  localparam int unsigned ROOT_W     = SLOT_W + 1;
  localparam int unsigned LEAF_AW    = SLOT_W + LIDX_W;
  localparam int unsigned LEAF_DEPTH = TablePool * EntriesPerTable;

  localparam logic [31:0] USER_HALF = 32'h8000_0000;

  // pte bit positions
  localparam int unsigned PTE_V = 0;
  localparam int unsigned PTE_W = 1;
  localparam int unsigned PTE_U = 2;
  localparam int unsigned PTE_R = 5;
  localparam int unsigned PTE_M = 6;

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_LOOKUP  = 3'd1;
  localparam logic [2:0] MODE_DELETE  = 3'd2;
  localparam logic [2:0] MODE_GETBITS = 3'd3;
  localparam logic [2:0] MODE_RECORD  = 3'd4;
  localparam logic [2:0] MODE_CLEAR   = 3'd5;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MISS     = 2'd1;
  localparam logic [1:0] STATUS_NO_TABLE = 2'd2;

endpackage

@@ sv/two_level_page_table_engine.sv @@
// Two-level page table engine. An item is taken when start is high and busy is low; its single
// result appears on the result ports for exactly one cycle with done_o high, and the receiver
// cannot stall it. Lookup, delete, get-bits and record-access go from acceptance through a root
// memory read and a leaf memory read to the done cycle, with the write-back of delete, get-bits
// and record-access; the next item can be accepted in the done cycle. Any item that finds its
// root entry invalid, an add to a valid root entry and an add that finds the pool empty end after
// the root memory read; the unused modes end without a memory read. An add that allocates a
// second-level table clears it one entry per cycle. Clear-space walks the 512 root entries one
// per cycle, and the same pass runs after reset; busy is high throughout. The space_is_current
// register is written through the cfg channel, which is always ready.
module two_level_page_table_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [31:0] virt_addr_i,
  input  logic [19:0] page_index_i,
  input  logic [19:0] frame_i,
  input  logic [1:0]  protection_i,
  input  logic        write_access_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] phys_addr_o,
  output logic        was_referenced_o,
  output logic        was_modified_o,
  output logic        tlb_flush_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROOT = 3'd1;
  localparam logic [2:0] ST_LEAF = 3'd2;
  localparam logic [2:0] ST_RCLR = 3'd3;
  localparam logic [2:0] ST_LCLR = 3'd4;

  localparam int unsigned LIDX_LO = tlpt_pkg::PAGE_SHIFT;
  localparam int unsigned RIDX_LO = tlpt_pkg::PAGE_SHIFT + tlpt_pkg::LIDX_W;

  logic [2:0]                    state_q, state_d;
  logic [tlpt_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          report_q, report_d;
  logic [tlpt_pkg::USED_W-1:0]   used_q, used_d;
  logic [tlpt_pkg::SLOT_W-1:0]   alloc_slot_q, alloc_slot_d;
  logic                          space_q;

  logic [2:0]  mode_q, mode_d;
  logic [31:0] va_q, va_d;
  logic [19:0] frame_q, frame_d;
  logic [1:0]  prot_q, prot_d;
  logic        wr_q, wr_d;

  logic        done_q, done_d;
  logic [1:0]  status_q, status_d;
  logic [31:0] phys_q, phys_d;
  logic        ref_q, ref_d;
  logic        mod_q, mod_d;
  logic        flush_q, flush_d;

  logic [tlpt_pkg::ROOT_W-1:0]  root_mem [tlpt_pkg::RootEntries];
  logic [tlpt_pkg::ROOT_W-1:0]  root_rd_q;
  logic [tlpt_pkg::RIDX_W-1:0]  root_raddr, root_waddr;
  logic [tlpt_pkg::ROOT_W-1:0]  root_wdata;
  logic                         root_we;

  logic [31:0]                  leaf_mem [tlpt_pkg::LEAF_DEPTH];
  logic [31:0]                  leaf_rd_q;
  logic [tlpt_pkg::LEAF_AW-1:0] leaf_raddr, leaf_waddr;
  logic [31:0]                  leaf_wdata;
  logic                         leaf_we;

  logic [31:0] eff_va;
  logic [31:0] pte_new;
  logic        root_hit;
  logic        fin;
  logic [1:0]  res_status;
  logic [31:0] res_phys;
  logic        res_ref, res_mod, res_flush;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign phys_addr_o      = phys_q;
  assign was_referenced_o = ref_q;
  assign was_modified_o   = mod_q;
  assign tlb_flush_o      = flush_q;

  // get-bits walks base plus index pages
  assign eff_va = ((mode_i == tlpt_pkg::MODE_GETBITS) ?
                   (virt_addr_i + {page_index_i, 12'd0}) : virt_addr_i) | tlpt_pkg::USER_HALF;

  assign pte_new  = {frame_q, 9'd0, ~prot_q[1], ~prot_q[0], 1'b1};
  assign root_hit = root_rd_q[tlpt_pkg::ROOT_W-1];

  assign root_raddr = (state_q == ST_IDLE) ? eff_va[RIDX_LO +: tlpt_pkg::RIDX_W]
                                           : va_q[RIDX_LO +: tlpt_pkg::RIDX_W];
  assign leaf_raddr = {root_rd_q[tlpt_pkg::SLOT_W-1:0], va_q[LIDX_LO +: tlpt_pkg::LIDX_W]};

  always_ff @(posedge clk_i) begin
    if (root_we) begin
      root_mem[root_waddr] <= root_wdata;
    end
    root_rd_q <= root_mem[root_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[leaf_waddr] <= leaf_wdata;
    end
    leaf_rd_q <= leaf_mem[leaf_raddr];
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    report_d     = report_q;
    used_d       = used_q;
    alloc_slot_d = alloc_slot_q;
    mode_d       = mode_q;
    va_d         = va_q;
    frame_d      = frame_q;
    prot_d       = prot_q;
    wr_d         = wr_q;
    done_d       = 1'b0;
    status_d     = status_q;
    phys_d       = phys_q;
    ref_d        = ref_q;
    mod_d        = mod_q;
    flush_d      = flush_q;
    root_we      = 1'b0;
    root_waddr   = va_q[RIDX_LO +: tlpt_pkg::RIDX_W];
    root_wdata   = '0;
    leaf_we      = 1'b0;
    leaf_waddr   = leaf_raddr;
    leaf_wdata   = leaf_rd_q;
    fin          = 1'b0;
    res_status   = tlpt_pkg::STATUS_OK;
    res_phys     = '0;
    res_ref      = 1'b0;
    res_mod      = 1'b0;
    res_flush    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          mode_d  = mode_i;
          va_d    = eff_va;
          frame_d = frame_i;
          prot_d  = protection_i;
          wr_d    = write_access_i;
          unique case (mode_i)
            tlpt_pkg::MODE_ADD, tlpt_pkg::MODE_LOOKUP, tlpt_pkg::MODE_DELETE,
            tlpt_pkg::MODE_GETBITS, tlpt_pkg::MODE_RECORD: begin
              state_d = ST_ROOT;
            end
            tlpt_pkg::MODE_CLEAR: begin
              state_d  = ST_RCLR;
              report_d = 1'b1;
              used_d   = '0;
              cnt_d    = '0;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_ROOT: begin
        if (root_hit) begin
          if (mode_q == tlpt_pkg::MODE_ADD) begin
            leaf_we    = 1'b1;
            leaf_wdata = pte_new;
            fin        = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_LEAF;
          end
        end else if (mode_q == tlpt_pkg::MODE_ADD) begin
          if (used_q >= tlpt_pkg::USED_W'(tlpt_pkg::TablePool)) begin
            fin        = 1'b1;
            res_status = tlpt_pkg::STATUS_NO_TABLE;
            state_d    = ST_IDLE;
          end else begin
            root_we      = 1'b1;
            root_wdata   = {1'b1, used_q[tlpt_pkg::SLOT_W-1:0]};
            alloc_slot_d = used_q[tlpt_pkg::SLOT_W-1:0];
            used_d       = used_q + 1'b1;
            cnt_d        = '0;
            state_d      = ST_LCLR;
          end
        end else begin
          fin        = 1'b1;
          res_status = tlpt_pkg::STATUS_MISS;
          state_d    = ST_IDLE;
        end
      end
      ST_LEAF: begin
        fin     = 1'b1;
        state_d = ST_IDLE;
        unique case (mode_q)
          tlpt_pkg::MODE_LOOKUP: begin
            if (leaf_rd_q[tlpt_pkg::PTE_V]) begin
              res_phys = {leaf_rd_q[31:12], va_q[11:0]};
            end else begin
              res_status = tlpt_pkg::STATUS_MISS;
            end
          end
          tlpt_pkg::MODE_DELETE: begin
            if (leaf_rd_q[tlpt_pkg::PTE_V]) begin
              leaf_we                      = 1'b1;
              leaf_wdata[tlpt_pkg::PTE_V]  = 1'b0;
              res_flush                    = space_q;
            end else begin
              res_status = tlpt_pkg::STATUS_MISS;
            end
          end
          tlpt_pkg::MODE_GETBITS: begin
            // bits are taken even from an entry that is no longer valid
            res_ref                     = leaf_rd_q[tlpt_pkg::PTE_R];
            res_mod                     = leaf_rd_q[tlpt_pkg::PTE_M];
            leaf_we                     = 1'b1;
            leaf_wdata[tlpt_pkg::PTE_R] = 1'b0;
            leaf_wdata[tlpt_pkg::PTE_M] = 1'b0;
          end
          tlpt_pkg::MODE_RECORD: begin
            if (leaf_rd_q[tlpt_pkg::PTE_V]) begin
              leaf_we                     = 1'b1;
              leaf_wdata[tlpt_pkg::PTE_R] = 1'b1;
              leaf_wdata[tlpt_pkg::PTE_M] = leaf_rd_q[tlpt_pkg::PTE_M] | wr_q;
            end else begin
              res_status = tlpt_pkg::STATUS_MISS;
            end
          end
          default: begin
            res_status = tlpt_pkg::STATUS_OK;
          end
        endcase
      end
      ST_RCLR: begin
        root_we    = 1'b1;
        root_waddr = cnt_q[tlpt_pkg::RIDX_W-1:0];
        root_wdata = '0;
        if (cnt_q[tlpt_pkg::RIDX_W-1:0] == tlpt_pkg::RIDX_W'(tlpt_pkg::RootEntries - 1)) begin
          cnt_d    = '0;
          state_d  = ST_IDLE;
          fin      = report_q;
          report_d = 1'b0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LCLR: begin
        // sweep the new table, dropping the added pte in at its own index
        leaf_we    = 1'b1;
        leaf_waddr = {alloc_slot_q, cnt_q[tlpt_pkg::LIDX_W-1:0]};
        leaf_wdata = (cnt_q[tlpt_pkg::LIDX_W-1:0] == va_q[LIDX_LO +: tlpt_pkg::LIDX_W]) ?
                     pte_new : 32'd0;
        if (cnt_q[tlpt_pkg::LIDX_W-1:0] ==
            tlpt_pkg::LIDX_W'(tlpt_pkg::EntriesPerTable - 1)) begin
          cnt_d   = '0;
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      done_d   = 1'b1;
      status_d = res_status;
      phys_d   = res_phys;
      ref_d    = res_ref;
      mod_d    = res_mod;
      flush_d  = res_flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RCLR;
      cnt_q    <= '0;
      report_q <= 1'b0;
      used_q   <= '0;
      space_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      report_q <= report_d;
      used_q   <= used_d;
      done_q   <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        space_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    alloc_slot_q <= alloc_slot_d;
    mode_q       <= mode_d;
    va_q         <= va_d;
    frame_q      <= frame_d;
    prot_q       <= prot_d;
    wr_q         <= wr_d;
    status_q     <= status_d;
    phys_q       <= phys_d;
    ref_q        <= ref_d;
    mod_q        <= mod_d;
    flush_q      <= flush_d;
  end

`ifndef SYNTHESIS
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) != ST_IDLE || $past(start)))
    else $error("result strobe without an item in flight");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= tlpt_pkg::USED_W'(tlpt_pkg::TablePool))
    else $error("table pool count out of range");

  a_flush_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && tlb_flush_o) |-> (space_q && status_o == tlpt_pkg::STATUS_OK))
    else $error("tlb flush without a current space");

  a_phys_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != tlpt_pkg::STATUS_OK) |-> (phys_addr_o == 32'd0))
    else $error("physical address on a failed item");
`endif

endmodule
